// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks in the rtl, clocked on clk, reset rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RAU_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rau: assertion failed");

// condition must never be seen outside reset
`define RAU_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rau: forbidden condition seen");

`endif

// ===== rtl/core/rau_pkg.sv =====
// ---------------------------------------------------------------------------
// rau_pkg
// types, codes and sizes shared by the rational arithmetic unit
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int KIND_WIDTH  = 3;
    localparam int EXP_WIDTH   = 6;
    localparam int ORDER_WIDTH = 2;
    localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);
    localparam int QUEUE_DEPTH = 2;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // operation codes of the kind field
    localparam logic [KIND_WIDTH-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_CMP = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_POW = 3'd5;

    // compare order codes
    localparam logic [ORDER_WIDTH-1:0] ORDER_LESS    = 2'd0;
    localparam logic [ORDER_WIDTH-1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_GREATER = 2'd2;
    localparam logic [ORDER_WIDTH-1:0] ORDER_NO_DEN  = 2'd3;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]        kind;
        logic signed [DATA_WIDTH-1:0] a_num;
        logic signed [DATA_WIDTH-1:0] a_den;
        logic signed [DATA_WIDTH-1:0] b_num;
        logic signed [DATA_WIDTH-1:0] b_den;
        logic [EXP_WIDTH-1:0]         exponent;
    } rau_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_num;
        logic signed [DATA_WIDTH-1:0] result_den;
        logic [ORDER_WIDTH-1:0]       order;
        logic                         zero_den_error;
    } rau_result_t;

    // work class picked by the front end
    typedef enum logic [2:0] {
        OP_DONE,
        OP_ADD,
        OP_MULT,
        OP_CMP,
        OP_POW
    } rau_op_t;

    // one queued transaction, operands already arranged for the back end
    typedef struct packed {
        rau_op_t                op;
        word_t                  v0;
        word_t                  v1;
        word_t                  v2;
        word_t                  v3;
        logic [EXP_WIDTH-1:0]   exponent;
        logic [ORDER_WIDTH-1:0] order;
        logic                   err;
    } rau_entry_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_ADD_G,
        ST_ADD_GW,
        ST_ADD_TW,
        ST_ADD_L,
        ST_ADD_Q1W,
        ST_ADD_T1,
        ST_ADD_Q2W,
        ST_ADD_T2,
        ST_NORM,
        ST_NORM_G,
        ST_NORM_GW,
        ST_NORM_DN,
        ST_NORM_DD,
        ST_CAN_G1,
        ST_CAN_G1W,
        ST_CAN_D0,
        ST_CAN_D1,
        ST_CAN_G2,
        ST_CAN_G2W,
        ST_CAN_D2,
        ST_CAN_D3,
        ST_PROD_1,
        ST_PROD_2,
        ST_MULT_FIN,
        ST_CMP_FIN,
        ST_POW_CHK,
        ST_POW_RN,
        ST_POW_RD,
        ST_POW_BN,
        ST_POW_BD,
        ST_POW_NX
    } rau_state_t;

endpackage

// ===== rtl/core/rau_divider.sv =====
// ---------------------------------------------------------------------------
// rau_divider
// signed truncating divider, one quotient bit per cycle, wraps at data width
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rau_pkg::word_t dividend,
    input  rau_pkg::word_t divisor,
    output logic           done,
    output rau_pkg::word_t quotient
);
    import rau_pkg::*;

    logic                 run_reg;
    logic                 fix_reg;
    logic                 done_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    word_t                quo_reg;
    word_t                rem_reg;
    word_t                den_reg;
    logic                 neg_reg;

    logic [DATA_WIDTH:0]  trial;
    logic                 ge;
    word_t                a_mag;
    word_t                b_mag;

    assign a_mag = dividend[DATA_WIDTH-1] ? ('0 - dividend) : dividend;
    assign b_mag = divisor[DATA_WIDTH-1] ? ('0 - divisor) : divisor;
    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, den_reg};
    assign ge    = !trial[DATA_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_WIDTH'(DATA_WIDTH - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= a_mag;
            rem_reg <= '0;
            den_reg <= b_mag;
            neg_reg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? trial[DATA_WIDTH-1:0] : {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], ge};
        end
        else if (fix_reg)
        begin
            // apply the sign, most negative value wraps onto itself
            quo_reg <= neg_reg ? ('0 - quo_reg) : quo_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `RAU_ASSERT(a_div_restart, start |-> !run_reg && !fix_reg)

endmodule

// ===== rtl/core/rau_gcd.sv =====
// ---------------------------------------------------------------------------
// rau_gcd
// binary gcd of two signed words by magnitude, one step per cycle
// ---------------------------------------------------------------------------
module rau_gcd (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  rau_pkg::word_t a,
    input  rau_pkg::word_t b,
    output logic           done,
    output rau_pkg::word_t g
);
    import rau_pkg::*;

    logic                 run_reg;
    logic                 done_reg;
    word_t                u_reg;
    word_t                v_reg;
    logic [CNT_WIDTH-1:0] k_reg;
    word_t                g_reg;
    logic                 zero_in;

    // a zero operand gives one
    assign zero_in = (a == '0) || (b == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= !zero_in;
                done_reg <= zero_in;
            end
            else if (run_reg && (u_reg == v_reg))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            u_reg <= a[DATA_WIDTH-1] ? ('0 - a) : a;
            v_reg <= b[DATA_WIDTH-1] ? ('0 - b) : b;
            k_reg <= '0;
            if (zero_in)
            begin
                g_reg <= word_t'(1);
            end
        end
        else if (run_reg)
        begin
            if (u_reg == v_reg)
            begin
                g_reg <= u_reg << k_reg;
            end
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== rtl/core/rau_queue.sv =====
// ---------------------------------------------------------------------------
// rau_queue
// short fifo of classified transactions between front and back end
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rau_pkg::rau_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output rau_pkg::rau_entry_t rd_entry,
    output logic                empty
);
    import rau_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    rau_entry_t         slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry = slots[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    `RAU_ASSERT_NEVER(a_q_underflow, pop && count_reg == '0)
    `RAU_ASSERT_NEVER(a_q_overflow, push && !pop && count_reg == CNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/core/rau_front.sv =====
// ---------------------------------------------------------------------------
// rau_front
// takes transactions, settles trivial cases and arranges operands
// ---------------------------------------------------------------------------
module rau_front (
    input  logic                start,
    input  rau_pkg::rau_item_t  item,
    output logic                busy,
    output logic                push,
    input  logic                full,
    output rau_pkg::rau_entry_t entry
);
    import rau_pkg::*;

    word_t an;
    word_t ad;
    word_t bn;
    word_t bd;
    word_t bn_neg;

    assign an     = word_t'(item.a_num);
    assign ad     = word_t'(item.a_den);
    assign bn     = word_t'(item.b_num);
    assign bd     = word_t'(item.b_den);
    assign bn_neg = '0 - bn;

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        entry          = '0;
        entry.op       = OP_DONE;
        entry.exponent = item.exponent;
        entry.order    = ORDER_LESS;
        case (item.kind)
            KIND_ADD, KIND_SUB:
            begin
                if (ad == '0 || bd == '0)
                begin
                    entry.err = 1'b1;
                end
                else
                begin
                    entry.op = OP_ADD;
                    entry.v0 = an;
                    entry.v1 = ad;
                    entry.v2 = (item.kind == KIND_SUB) ? bn_neg : bn;
                    entry.v3 = bd;
                end
            end
            KIND_MUL:
            begin
                // pairs (an, bd) and (ad, bn) cancel against each other
                if (ad == '0 || bd == '0)
                begin
                    entry.err = 1'b1;
                end
                else
                begin
                    entry.op = OP_MULT;
                    entry.v0 = an;
                    entry.v1 = bd;
                    entry.v2 = ad;
                    entry.v3 = bn;
                end
            end
            KIND_DIV:
            begin
                // second operand flipped
                if (ad == '0 || bn == '0)
                begin
                    entry.err = 1'b1;
                end
                else
                begin
                    entry.op = OP_MULT;
                    entry.v0 = an;
                    entry.v1 = bn;
                    entry.v2 = ad;
                    entry.v3 = bd;
                end
            end
            KIND_CMP:
            begin
                if (bd == '0)
                begin
                    entry.order = ORDER_NO_DEN;
                end
                else if ((an == bn && ad == bd) || (an == '0 && bn == '0))
                begin
                    entry.order = ORDER_EQUAL;
                end
                else if (item.a_num < 0 && item.b_num > 0)
                begin
                    entry.order = ORDER_LESS;
                end
                else if (item.a_num > 0 && item.b_num < 0)
                begin
                    entry.order = ORDER_GREATER;
                end
                else
                begin
                    entry.op = OP_CMP;
                    entry.v0 = an;
                    entry.v1 = bn;
                    entry.v2 = ad;
                    entry.v3 = bd;
                end
            end
            KIND_POW:
            begin
                entry.op = OP_POW;
                entry.v0 = an;
                entry.v1 = ad;
            end
            default:
            begin
                entry.op = OP_DONE;
            end
        endcase
    end

endmodule

// ===== rtl/core/rau_back.sv =====
// ---------------------------------------------------------------------------
// rau_back
// sequencer that carries out one transaction on shared gcd, divider, multiplier
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  rau_pkg::rau_entry_t  entry,
    output logic                 pop,
    output logic                 done,
    output rau_pkg::rau_result_t result
);
    import rau_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;

    rau_state_t               state_reg, state_next;
    rau_op_t                  op_reg, op_next;
    word_t                    v0_reg, v0_next;
    word_t                    v1_reg, v1_next;
    word_t                    v2_reg, v2_next;
    word_t                    v3_reg, v3_next;
    word_t                    x_reg, x_next;
    word_t                    y_reg, y_next;
    logic [EXP_WIDTH-1:0]     exp_reg, exp_next;
    logic signed [PW-1:0]     mul_reg, mul_next;
    logic signed [PW-1:0]     p_reg, p_next;
    rau_result_t              res_reg, res_next;
    logic                     done_reg, done_next;

    logic  div_start, div_done;
    word_t div_a, div_b, div_q;
    logic  gcd_start, gcd_done;
    word_t gcd_a, gcd_b, gcd_g;
    word_t prod_lo;
    word_t prev_lo;

    function automatic logic signed [PW-1:0] mul_full(input word_t a, input word_t b);
        mul_full = $signed(a) * $signed(b);
    endfunction

    function automatic rau_result_t pack_res(input word_t num, input word_t den,
                                             input logic [ORDER_WIDTH-1:0] ord,
                                             input logic err);
        pack_res.result_num     = err ? '0 : num;
        pack_res.result_den     = err ? '0 : den;
        pack_res.order          = ord;
        pack_res.zero_den_error = err;
    endfunction

    rau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    rau_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (gcd_a),
        .b     (gcd_b),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    assign prod_lo = mul_reg[DATA_WIDTH-1:0];
    assign prev_lo = p_reg[DATA_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        v0_reg  <= v0_next;
        v1_reg  <= v1_next;
        v2_reg  <= v2_next;
        v3_reg  <= v3_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        exp_reg <= exp_next;
        mul_reg <= mul_next;
        p_reg   <= p_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        v3_next    = v3_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        exp_next   = exp_reg;
        mul_next   = mul_reg;
        p_next     = p_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_a      = v0_reg;
        div_b      = v1_reg;
        gcd_start  = 1'b0;
        gcd_a      = v0_reg;
        gcd_b      = v1_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    op_next  = entry.op;
                    v0_next  = entry.v0;
                    v1_next  = entry.v1;
                    v2_next  = entry.v2;
                    v3_next  = entry.v3;
                    exp_next = entry.exponent;
                    case (entry.op)
                        OP_ADD:
                        begin
                            state_next = ST_ADD_G;
                        end
                        OP_MULT, OP_CMP:
                        begin
                            state_next = ST_CAN_G1;
                        end
                        OP_POW:
                        begin
                            v2_next    = word_t'(1);
                            v3_next    = word_t'(1);
                            state_next = ST_POW_CHK;
                        end
                        default:
                        begin
                            res_next  = pack_res('0, '0, entry.order, entry.err);
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // lcm of the denominators, then scale both numerators
            ST_ADD_G:
            begin
                gcd_start  = 1'b1;
                gcd_a      = v1_reg;
                gcd_b      = v3_reg;
                state_next = ST_ADD_GW;
            end
            ST_ADD_GW:
            begin
                div_a = v1_reg;
                div_b = gcd_g;
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_ADD_TW;
                end
            end
            ST_ADD_TW:
            begin
                if (div_done)
                begin
                    mul_next   = mul_full(div_q, v3_reg);
                    state_next = ST_ADD_L;
                end
            end
            ST_ADD_L:
            begin
                y_next     = prod_lo;
                div_start  = 1'b1;
                div_a      = prod_lo;
                div_b      = v1_reg;
                state_next = ST_ADD_Q1W;
            end
            ST_ADD_Q1W:
            begin
                if (div_done)
                begin
                    mul_next   = mul_full(div_q, v0_reg);
                    state_next = ST_ADD_T1;
                end
            end
            ST_ADD_T1:
            begin
                x_next     = prod_lo;
                div_start  = 1'b1;
                div_a      = y_reg;
                div_b      = v3_reg;
                state_next = ST_ADD_Q2W;
            end
            ST_ADD_Q2W:
            begin
                if (div_done)
                begin
                    mul_next   = mul_full(div_q, v2_reg);
                    state_next = ST_ADD_T2;
                end
            end
            ST_ADD_T2:
            begin
                v0_next    = x_reg + prod_lo;
                v1_next    = y_reg;
                state_next = ST_NORM;
            end

            // sign fix and reduction of v0 / v1
            ST_NORM:
            begin
                if (v1_reg == '0)
                begin
                    res_next   = pack_res('0, '0, ORDER_LESS, 1'b1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (v0_reg == '0)
                begin
                    res_next   = pack_res('0, word_t'(1), ORDER_LESS, 1'b0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (v1_reg[DATA_WIDTH-1])
                    begin
                        v0_next = '0 - v0_reg;
                        v1_next = '0 - v1_reg;
                    end
                    state_next = ST_NORM_G;
                end
            end
            ST_NORM_G:
            begin
                gcd_start  = 1'b1;
                state_next = ST_NORM_GW;
            end
            ST_NORM_GW:
            begin
                div_b = gcd_g;
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_NORM_DN;
                end
            end
            ST_NORM_DN:
            begin
                div_a = v1_reg;
                div_b = gcd_g;
                if (div_done)
                begin
                    v0_next    = div_q;
                    div_start  = 1'b1;
                    state_next = ST_NORM_DD;
                end
            end
            ST_NORM_DD:
            begin
                if (div_done)
                begin
                    res_next   = pack_res(v0_reg, div_q, ORDER_LESS, 1'b0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // cross cancellation: pair v0/v1, then pair v2/v3
            ST_CAN_G1:
            begin
                gcd_start  = 1'b1;
                state_next = ST_CAN_G1W;
            end
            ST_CAN_G1W:
            begin
                div_b = gcd_g;
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_CAN_D0;
                end
            end
            ST_CAN_D0:
            begin
                div_a = v1_reg;
                div_b = gcd_g;
                if (div_done)
                begin
                    v0_next    = div_q;
                    div_start  = 1'b1;
                    state_next = ST_CAN_D1;
                end
            end
            ST_CAN_D1:
            begin
                if (div_done)
                begin
                    v1_next    = div_q;
                    state_next = ST_CAN_G2;
                end
            end
            ST_CAN_G2:
            begin
                gcd_start  = 1'b1;
                gcd_a      = v2_reg;
                gcd_b      = v3_reg;
                state_next = ST_CAN_G2W;
            end
            ST_CAN_G2W:
            begin
                div_a = v2_reg;
                div_b = gcd_g;
                if (gcd_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_CAN_D2;
                end
            end
            ST_CAN_D2:
            begin
                div_a = v3_reg;
                div_b = gcd_g;
                if (div_done)
                begin
                    v2_next    = div_q;
                    div_start  = 1'b1;
                    state_next = ST_CAN_D3;
                end
            end
            ST_CAN_D3:
            begin
                if (div_done)
                begin
                    v3_next    = div_q;
                    state_next = ST_PROD_1;
                end
            end
            ST_PROD_1:
            begin
                mul_next   = mul_full(v0_reg, v3_reg);
                state_next = ST_PROD_2;
            end
            ST_PROD_2:
            begin
                p_next     = mul_reg;
                mul_next   = mul_full(v2_reg, v1_reg);
                state_next = (op_reg == OP_CMP) ? ST_CMP_FIN : ST_MULT_FIN;
            end
            ST_MULT_FIN:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (prod_lo == '0)
                begin
                    res_next = pack_res('0, '0, ORDER_LESS, 1'b1);
                end
                else if (prev_lo == '0)
                begin
                    res_next = pack_res('0, word_t'(1), ORDER_LESS, 1'b0);
                end
                else if (prod_lo[DATA_WIDTH-1])
                begin
                    res_next = pack_res('0 - prev_lo, '0 - prod_lo, ORDER_LESS, 1'b0);
                end
                else
                begin
                    res_next = pack_res(prev_lo, prod_lo, ORDER_LESS, 1'b0);
                end
            end
            ST_CMP_FIN:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (p_reg < mul_reg)
                begin
                    res_next = pack_res('0, '0, ORDER_LESS, 1'b0);
                end
                else if (p_reg > mul_reg)
                begin
                    res_next = pack_res('0, '0, ORDER_GREATER, 1'b0);
                end
                else
                begin
                    res_next = pack_res('0, '0, ORDER_EQUAL, 1'b0);
                end
            end

            // square and multiply, v0/v1 bases, v2/v3 running results
            ST_POW_CHK:
            begin
                if (exp_reg == '0)
                begin
                    res_next   = pack_res(v2_reg, v3_reg, ORDER_LESS, v3_reg == '0);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_POW_RN;
                end
            end
            ST_POW_RN:
            begin
                mul_next   = mul_full(v2_reg, v0_reg);
                state_next = ST_POW_RD;
            end
            ST_POW_RD:
            begin
                if (exp_reg[0])
                begin
                    v2_next = prod_lo;
                end
                mul_next   = mul_full(v3_reg, v1_reg);
                state_next = ST_POW_BN;
            end
            ST_POW_BN:
            begin
                if (exp_reg[0])
                begin
                    v3_next = prod_lo;
                end
                mul_next   = mul_full(v0_reg, v0_reg);
                state_next = ST_POW_BD;
            end
            ST_POW_BD:
            begin
                v0_next    = prod_lo;
                mul_next   = mul_full(v1_reg, v1_reg);
                state_next = ST_POW_NX;
            end
            ST_POW_NX:
            begin
                v1_next    = prod_lo;
                exp_next   = exp_reg >> 1;
                state_next = ST_POW_CHK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

    `RAU_ASSERT(a_err_clears, done_reg && res_reg.zero_den_error |-> res_reg.result_num == '0 && res_reg.result_den == '0 && res_reg.order == ORDER_LESS)
    `RAU_ASSERT(a_order_only_cmp, done_reg && res_reg.order != ORDER_LESS |-> !res_reg.zero_den_error && res_reg.result_num == '0 && res_reg.result_den == '0)

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide, compare and power on signed fractions
// ---------------------------------------------------------------------------
// A transaction is taken at a rising edge where start is high and busy is
// low. Each one yields exactly one result on result, marked by done for a
// single cycle; there is no way to hold results off, so capture them when
// done is high. Results come out in the order the transactions went in.
// A front end classifies each transaction and answers the trivial cases
// (zero denominators, early compare decisions, unused kinds); up to two
// transactions wait in a queue while the back end works, so busy only rises
// once the queue is full. The back end shares one divider and one binary
// gcd among all its steps. Add/subtract run two gcd passes and five
// divisions, or only one gcd pass and three divisions when the sum or its
// denominator comes out zero; multiply, divide and compare run two gcd
// passes and four divisions; power runs a check, two result products and
// two base squarings per exponent bit position; trivial cases need neither
// gcd nor division.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rau_pkg::rau_item_t   item,
    output logic                 busy,
    output logic                 done,
    output rau_pkg::rau_result_t result
);
    import rau_pkg::*;

    // front to queue
    logic       push;
    logic       full;
    rau_entry_t wr_entry;

    // queue to back end
    logic       pop;
    logic       empty;
    rau_entry_t rd_entry;

    // classify and settle the cheap cases at the door
    rau_front u_front (
        .start (start),
        .item  (item),
        .busy  (busy),
        .push  (push),
        .full  (full),
        .entry (wr_entry)
    );

    // decouples acceptance from the long-running back end
    rau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .rd_entry (rd_entry),
        .empty    (empty)
    );

    // gcd, division and multiply sequencer, one transaction at a time
    rau_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .entry  (rd_entry),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// ===== dv/rau_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rau_checker
// watches the item and result channels of the rational arithmetic unit,
// predicts each result with its own fraction arithmetic and compares in order
// ---------------------------------------------------------------------------
module rau_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  rau_pkg::rau_item_t   item,
    input  logic                 done,
    input  rau_pkg::rau_result_t result,
    output int                   mismatches,
    output int                   pending
);
    import rau_pkg::*;

    rau_result_t expected_results[$];

    // signed wrap to the data width
    function automatic longint wrapw(longint x);
        logic [DATA_WIDTH-1:0] low;
        low = x[DATA_WIDTH-1:0];
        return longint'($signed(low));
    endfunction

    function automatic longint qdiv(longint a, longint b, ref bit err);
        if (b == 0)
        begin
            err = 1'b1;
            return 0;
        end
        return wrapw(a / b);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return wrapw(a * b);
    endfunction

    function automatic longint gcd_of(longint a, longint b);
        longint r;
        if (a == 0 || b == 0)
            return 1;
        r = a % b;
        while (r != 0)
        begin
            a = b;
            b = r;
            r = a % b;
        end
        return wrapw(b > 0 ? b : -b);
    endfunction

    function automatic void reduce_frac(ref longint n, ref longint d, ref bit err);
        longint g;
        if (d == 0)
        begin
            err = 1'b1;
            return;
        end
        if (n == 0)
        begin
            d = 1;
            return;
        end
        if (d < 0)
        begin
            n = wrapw(-n);
            d = wrapw(-d);
        end
        g = gcd_of(n, d);
        n = qdiv(n, g, err);
        d = qdiv(d, g, err);
    endfunction

    function automatic void sum_frac(longint an, longint ad, longint bn, longint bd,
                                     ref longint rn, ref longint rd, ref bit err);
        longint l;
        longint t1;
        longint t2;
        l  = qmul(qdiv(ad, gcd_of(ad, bd), err), bd);
        t1 = qmul(qdiv(l, ad, err), an);
        t2 = qmul(qdiv(l, bd, err), bn);
        rn = wrapw(t1 + t2);
        rd = l;
        if (!err)
            reduce_frac(rn, rd, err);
    endfunction

    function automatic void product_frac(longint an, longint ad, longint bn, longint bd,
                                         ref longint rn, ref longint rd, ref bit err);
        longint g1;
        longint g2;
        g1 = gcd_of(an, bd);
        g2 = gcd_of(ad, bn);
        an = qdiv(an, g1, err);
        bd = qdiv(bd, g1, err);
        ad = qdiv(ad, g2, err);
        bn = qdiv(bn, g2, err);
        rn = qmul(an, bn);
        rd = qmul(ad, bd);
        if (rd == 0)
        begin
            err = 1'b1;
            return;
        end
        if (rn == 0)
        begin
            rd = 1;
            return;
        end
        if (rd < 0)
        begin
            rn = wrapw(-rn);
            rd = wrapw(-rd);
        end
    endfunction

    function automatic logic [ORDER_WIDTH-1:0] order_of(longint an, longint ad,
                                                       longint bn, longint bd);
        bit     e;
        longint g;
        longint p;
        longint q;
        e = 1'b0;
        if (bd == 0)
            return ORDER_NO_DEN;
        if ((an == bn && ad == bd) || (an == 0 && bn == 0))
            return ORDER_EQUAL;
        if (an < 0 && bn > 0)
            return ORDER_LESS;
        if (an > 0 && bn < 0)
            return ORDER_GREATER;
        g  = gcd_of(an, bn);
        an = qdiv(an, g, e);
        bn = qdiv(bn, g, e);
        g  = gcd_of(ad, bd);
        ad = qdiv(ad, g, e);
        bd = qdiv(bd, g, e);
        // cross products at full 64 bits, no wrap
        p = an * bd;
        q = ad * bn;
        if (p < q)
            return ORDER_LESS;
        if (p > q)
            return ORDER_GREATER;
        return ORDER_EQUAL;
    endfunction

    function automatic longint power_of(longint base, logic [EXP_WIDTH-1:0] ex);
        longint r;
        r = 1;
        while (ex != 0)
        begin
            if (ex[0])
                r = qmul(r, base);
            base = qmul(base, base);
            ex = ex >> 1;
        end
        return r;
    endfunction

    function automatic rau_result_t predict_result(rau_item_t it);
        longint      an;
        longint      ad;
        longint      bn;
        longint      bd;
        longint      rn;
        longint      rd;
        bit          err;
        rau_result_t r;
        an  = longint'(it.a_num);
        ad  = longint'(it.a_den);
        bn  = longint'(it.b_num);
        bd  = longint'(it.b_den);
        rn  = 0;
        rd  = 0;
        err = 1'b0;
        r   = '0;
        case (it.kind)
            KIND_ADD: sum_frac(an, ad, bn, bd, rn, rd, err);
            KIND_SUB: sum_frac(an, ad, wrapw(-bn), bd, rn, rd, err);
            KIND_MUL: product_frac(an, ad, bn, bd, rn, rd, err);
            KIND_DIV: product_frac(an, ad, bd, bn, rn, rd, err);
            KIND_CMP: r.order = order_of(an, ad, bn, bd);
            KIND_POW:
            begin
                rn = power_of(an, it.exponent);
                rd = power_of(ad, it.exponent);
                if (rd == 0)
                    err = 1'b1;
            end
            default: ;
        endcase
        if (err)
        begin
            rn = 0;
            rd = 0;
        end
        r.result_num     = rn[DATA_WIDTH-1:0];
        r.result_den     = rd[DATA_WIDTH-1:0];
        r.zero_den_error = err;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rau_result_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.result_num !== want.result_num
                        || result.result_den !== want.result_den
                        || result.order !== want.order
                        || result.zero_den_error !== want.zero_den_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "mismatch: exp %0d/%0d ord %0d err %0d, got %0d/%0d ord %0d err %0d",
                                want.result_num, want.result_den, want.order,
                                want.zero_den_error, result.result_num,
                                result.result_den, result.order,
                                result.zero_den_error);
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_result(item));
            pending = expected_results.size();
        end
    end

endmodule

// ===== dv/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// drives directed and random fraction transactions into the unit with random
// gaps; a checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    rau_item_t   item;
    logic        busy;
    logic        done;
    rau_result_t result;
    int          mismatches;
    int          pending;
    int          cycles;

    rational_arithmetic_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    rau_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter guards against a hung block; past its limit the run stops
    // and reports a failure
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 4000000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // operand picker: mostly small values so gcd and cancel paths get real
    // work, plus the corner values and some full-range noise
    function automatic logic [DATA_WIDTH-1:0] pick_operand(bit allow_zero);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return DATA_WIDTH'($signed($urandom_range(0, 60)) - 30);
        else if (sel < 60)
            return DATA_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
        else if (sel < 70)
        begin
            case ($urandom_range(0, 5))
                0: return allow_zero ? '0 : 1;
                1: return 1;
                2: return '1;
                3: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
                4: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
                default: return DATA_WIDTH'($urandom_range(1, 8)) << $urandom_range(0, 28);
            endcase
        end
        else
            return $urandom;
    endfunction

    function automatic rau_item_t make_item(logic [KIND_WIDTH-1:0] k, int a_n, int a_d,
                                            int b_n, int b_d, int ex);
        rau_item_t it;
        it.kind     = k;
        it.a_num    = a_n;
        it.a_den    = a_d;
        it.b_num    = b_n;
        it.b_den    = b_d;
        it.exponent = ex[EXP_WIDTH-1:0];
        return it;
    endfunction

    // present one transaction and hold it until the block takes it; busy is
    // sampled on the falling edge so acceptance is known before the rising one
    task automatic send_item(rau_item_t it);
        bit taken;
        start <= 1'b1;
        item  <= it;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    // random gap after a transaction: mostly none or short, a few long
    task automatic idle_gap(bit quiet);
        int n;
        int sel;
        if (quiet)
            return;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            n = 0;
        else if (sel < 92)
            n = $urandom_range(1, 6);
        else
            n = $urandom_range(20, 400);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one edge first so the checker has counted the last accepted transaction
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    localparam int MIN_W = 32'h8000_0000;
    localparam int MAX_W = 32'h7fff_ffff;

    rau_item_t directed[$];

    initial
    begin
        rau_item_t it;
        int        kind_sel;
        bit        quiet;

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every kind, corner operands, zero denominators,
        // wrap of most-negative values, compare early exits, power extremes
        directed.push_back(make_item(KIND_ADD, 1, 2, 1, 3, 0));
        directed.push_back(make_item(KIND_SUB, 1, 2, 1, 2, 0));
        directed.push_back(make_item(KIND_ADD, 3, -4, -5, 6, 0));
        directed.push_back(make_item(KIND_ADD, 1, 0, 1, 2, 0));
        directed.push_back(make_item(KIND_SUB, MIN_W, 1, MIN_W, 1, 0));
        directed.push_back(make_item(KIND_ADD, MAX_W, MAX_W, MIN_W, MIN_W, 0));
        directed.push_back(make_item(KIND_MUL, 6, 35, 14, 15, 0));
        directed.push_back(make_item(KIND_MUL, 0, -7, 3, 5, 0));
        directed.push_back(make_item(KIND_MUL, MIN_W, -1, 1, 1, 0));
        directed.push_back(make_item(KIND_MUL, 65536, 1, 1, 65536, 0));
        directed.push_back(make_item(KIND_DIV, 2, 3, 0, 5, 0));
        directed.push_back(make_item(KIND_DIV, -4, 9, 2, -3, 0));
        directed.push_back(make_item(KIND_CMP, 1, 2, 1, 0, 0));
        directed.push_back(make_item(KIND_CMP, 0, 3, 0, -5, 0));
        directed.push_back(make_item(KIND_CMP, -1, 2, 1, 2, 0));
        directed.push_back(make_item(KIND_CMP, 1, 2, -1, 2, 0));
        directed.push_back(make_item(KIND_CMP, 2, 3, 3, 4, 0));
        directed.push_back(make_item(KIND_CMP, MAX_W, MIN_W, MAX_W, MAX_W, 0));
        directed.push_back(make_item(KIND_POW, 3, -2, 0, 0, 0));
        directed.push_back(make_item(KIND_POW, -3, 7, 0, 0, 63));
        directed.push_back(make_item(KIND_POW, 5, 2, 0, 0, 13));
        directed.push_back(make_item(KIND_POW, 1, 0, 0, 0, 5));
        directed.push_back(make_item(KIND_POW, 2, 2, 0, 0, 32));
        directed.push_back(make_item(3'd6, -1, -1, -1, -1, 63));
        directed.push_back(make_item(3'd7, MAX_W, 1, 2, 3, 1));
        foreach (directed[i])
        begin
            send_item(directed[i]);
            idle_gap(1'b0);
        end

        // hold off until the block has answered everything once
        start <= 1'b0;
        wait_drained();
        @(posedge clk);

        for (int n = 0; n < 1700; n++)
        begin
            // a stretch with no idling in the middle of the run
            quiet = (n >= 800 && n < 900);
            kind_sel = $urandom_range(0, 99);
            if (kind_sel < 96)
                it.kind = KIND_WIDTH'(kind_sel % 6);
            else
                it.kind = KIND_WIDTH'($urandom_range(6, 7));
            it.a_num = pick_operand(1'b1);
            it.b_num = pick_operand(1'b1);
            // zero corner value for denominators now and then; random ranges can give zero too
            it.a_den = pick_operand($urandom_range(0, 19) == 0);
            it.b_den = pick_operand($urandom_range(0, 19) == 0);
            // equal operands exercise the compare shortcut and exact cancel
            if ($urandom_range(0, 19) == 0)
            begin
                it.b_num = it.a_num;
                it.b_den = it.a_den;
            end
            it.exponent = EXP_WIDTH'($urandom);
            send_item(it);
            idle_gap(quiet);
            if (n == 1200)
            begin
                start <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
        end

        start <= 1'b0;
        wait_drained();
        // let the back end settle in case anything stray comes out
        repeat (500) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rau_gcd.sv
rtl/core/rau_queue.sv
rtl/core/rau_front.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
dv/rau_checker.sv
dv/rational_arithmetic_unit_tb.sv
